[sv/mmm_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmm_pkg: shared types and codes of the mesh matrix multiplier
// Item and result payload structs, operation codes and register indexes.
// ---------------------------------------------------------------------------
package mmm_pkg;

  // Operation codes carried by an input item.
  localparam logic [1:0] OP_LOAD_A   = 2'd0;
  localparam logic [1:0] OP_LOAD_B   = 2'd1;
  localparam logic [1:0] OP_RUN      = 2'd2;
  localparam logic [1:0] OP_RESERVED = 2'd3;

  // Configuration register indexes (word address bits [3:2]).
  localparam logic [1:0] REG_ROWS  = 2'd0;
  localparam logic [1:0] REG_COLS  = 2'd1;
  localparam logic [1:0] REG_INNER = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [31:0] product_sum;
    logic               last;
  } result_t;

  // Per-row control shared by every cell of one mesh row.
  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

endpackage

[sv/mmm_skew.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmm_skew: edge skew delay line
// Delays one operand stream with its valid bit by a fixed number of cycles.
// ---------------------------------------------------------------------------
module mmm_skew #(
  parameter int DEPTH = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] d,
  input  logic        dv,
  output logic [31:0] q,
  output logic        qv
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q  = d;
      assign qv = dv;
    end else begin : g_line
      logic [31:0] tap   [DEPTH];
      logic        tap_v [DEPTH];

      // Shift the operand one stage per cycle.
      always_ff @(posedge clk) begin
        tap[0] <= d;
        for (int i = 1; i < DEPTH; i++) begin
          tap[i] <= tap[i-1];
        end
      end

      // Valid bits are control state and clear on reset.
      always_ff @(posedge clk) begin
        if (rst) begin
          for (int i = 0; i < DEPTH; i++) begin
            tap_v[i] <= 1'b0;
          end
        end else begin
          tap_v[0] <= dv;
          for (int i = 1; i < DEPTH; i++) begin
            tap_v[i] <= tap_v[i-1];
          end
        end
      end

      assign q  = tap[DEPTH-1];
      assign qv = tap_v[DEPTH-1];
    end
  endgenerate

endmodule

[sv/mmm_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmm_cell: multiply-accumulate cell of the mesh
// Passes A right and B down, multiplies, accumulates, and shifts its sum
// left when the row is being drained.
// ---------------------------------------------------------------------------
module mmm_cell
  import mmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cell_ctrl_t  ctrl,
  input  logic [31:0] a_in,
  input  logic        a_in_v,
  input  logic [31:0] b_in,
  input  logic [31:0] sum_in,
  output logic [31:0] a_out,
  output logic        a_out_v,
  output logic [31:0] b_out,
  output logic [31:0] sum
);

  logic [31:0] prod;
  logic        prod_v;
  logic [63:0] full_prod;

  assign full_prod = 64'(a_in) * 64'(b_in);

  // Operand forwarding and product register.
  always_ff @(posedge clk) begin
    a_out <= a_in;
    b_out <= b_in;
    prod  <= full_prod[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_out_v <= 1'b0;
      prod_v  <= 1'b0;
    end else begin
      a_out_v <= a_in_v;
      prod_v  <= a_in_v;
    end
  end

  // Accumulator: cleared at run start, shifted left while draining.
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      sum <= '0;
    end else if (ctrl.shift) begin
      sum <= sum_in;
    end else if (prod_v) begin
      sum <= sum + prod;
    end
  end

endmodule

[sv/mesh_matrix_multiply.sv]
`timescale 1ns / 1ps
// A run steps through FEED for the saturated inner length, waits in WAIT for the mesh to
// fill and drain, then emits one result per cycle (nr * nc) while the output is free.
// Loads are taken whenever idle; items are refused from a run until its last result
// is in the output register. Throughput is set by the mesh fill and drain.
// Reset (synchronous, active high) restores the registers to 8, 8, 16 and idles;
// the A and B stores hold no defined value until written.
// ---------------------------------------------------------------------------
// mesh_matrix_multiply: systolic mesh matrix multiplier
// Loads A and B elements into per-row and per-column stores, streams them with
// edge skew through an R x C mesh of MAC cells, and drains sums in row order.
// ---------------------------------------------------------------------------
module mesh_matrix_multiply
  import mmm_pkg::*;
#(
  parameter int MAX_ROWS  = 8,
  parameter int MAX_COLS  = 8,
  parameter int MAX_INNER = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  localparam int KW    = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int DRAIN = MAX_ROWS + MAX_COLS + 3;
  localparam int WW    = $clog2(DRAIN + 1);

  typedef enum logic [1:0] {IDLE, FEED, WAIT, EMIT} state_t;

  state_t      state;
  logic [3:0]  rows_used;
  logic [3:0]  cols_used;
  logic [4:0]  inner_len;
  logic [4:0]  nr;
  logic [4:0]  nc;
  logic [8:0]  nk;
  logic [8:0]  kcnt;
  logic [WW-1:0] wcnt;
  logic [RW-1:0] er;
  logic [CW-1:0] ec;
  logic        feed_v;
  logic        rd_v;
  logic        clr;
  logic        accept;
  logic        emit_go;
  logic        emit_last;
  logic        cfg_wr;

  logic [31:0] a_rd     [MAX_ROWS];
  logic [31:0] b_rd     [MAX_COLS];
  logic [31:0] a_link   [MAX_ROWS][MAX_COLS+1];
  logic        av_link  [MAX_ROWS][MAX_COLS+1];
  logic [31:0] b_link   [MAX_ROWS+1][MAX_COLS];
  logic [31:0] sum_link [MAX_ROWS][MAX_COLS+1];
  logic [31:0] row_head [MAX_ROWS];
  cell_ctrl_t  row_ctrl [MAX_ROWS];

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_used <= 4'd8;
      cols_used <= 4'd8;
      inner_len <= 5'd16;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ROWS:  rows_used <= pwdata[3:0];
        REG_COLS:  cols_used <= pwdata[3:0];
        REG_INNER: inner_len <= pwdata[4:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ROWS:  prdata = {28'd0, rows_used};
      REG_COLS:  prdata = {28'd0, cols_used};
      REG_INNER: prdata = {27'd0, inner_len};
      default:   prdata = '0;
    endcase
  end

  // Effective dimensions, saturated to the mesh and store sizes; zero counts as one.
  always_comb begin
    if (rows_used == 4'd0) nr = 5'd1;
    else if ({1'b0, rows_used} > 5'(MAX_ROWS)) nr = 5'(MAX_ROWS);
    else nr = {1'b0, rows_used};
    if (cols_used == 4'd0) nc = 5'd1;
    else if ({1'b0, cols_used} > 5'(MAX_COLS)) nc = 5'(MAX_COLS);
    else nc = {1'b0, cols_used};
    if (inner_len == 5'd0) nk = 9'd1;
    else if ({4'd0, inner_len} > 9'(MAX_INNER)) nk = 9'(MAX_INNER);
    else nk = {4'd0, inner_len};
  end

  assign item_stall = (state != IDLE);
  assign accept     = item_valid && !item_stall;
  assign clr        = accept && (item.operation == OP_RUN);
  assign feed_v     = (state == FEED);
  assign emit_go    = (state == EMIT) && (!result_valid || !result_stall);
  assign emit_last  = ({{(5-RW){1'b0}}, er} == 5'(nr - 5'd1)) &&
                      ({{(5-CW){1'b0}}, ec} == 5'(nc - 5'd1));

  // Row stores of A and column stores of B, read at the current inner step.
  generate
    for (genvar r = 0; r < MAX_ROWS; r++) begin : g_amem
      logic [31:0] mem [MAX_INNER];
      always_ff @(posedge clk) begin
        if (accept && item.operation == OP_LOAD_A && int'(item.row_index) == r &&
            int'(item.col_index) < MAX_INNER) begin
          mem[KW'(item.col_index)] <= item.value;
        end
        a_rd[r] <= mem[kcnt[KW-1:0]];
      end
    end
    for (genvar c = 0; c < MAX_COLS; c++) begin : g_bmem
      logic [31:0] mem [MAX_INNER];
      always_ff @(posedge clk) begin
        if (accept && item.operation == OP_LOAD_B && int'(item.col_index) == c &&
            int'(item.row_index) < MAX_INNER) begin
          mem[KW'(item.row_index)] <= item.value;
        end
        b_rd[c] <= mem[kcnt[KW-1:0]];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) rd_v <= 1'b0;
    else     rd_v <= feed_v;
  end

  // Edge skew: row r and column c pass through mmm_skew lines with DEPTH set to r and c.
  generate
    for (genvar r = 0; r < MAX_ROWS; r++) begin : g_askew
      mmm_skew #(.DEPTH(r)) u_skew (
        .clk (clk), .rst (rst), .d (a_rd[r]), .dv (rd_v),
        .q   (a_link[r][0]), .qv (av_link[r][0])
      );
    end
    for (genvar c = 0; c < MAX_COLS; c++) begin : g_bskew
      logic unused_v;
      mmm_skew #(.DEPTH(c)) u_skew (
        .clk (clk), .rst (rst), .d (b_rd[c]), .dv (rd_v),
        .q   (b_link[0][c]), .qv (unused_v)
      );
    end
  endgenerate

  // The mesh of MAC cells.
  generate
    for (genvar r = 0; r < MAX_ROWS; r++) begin : g_row
      assign row_ctrl[r].clr   = clr;
      assign row_ctrl[r].shift = emit_go && (int'(er) == r);
      assign sum_link[r][MAX_COLS] = '0;
      assign row_head[r] = sum_link[r][0];
      for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
        mmm_cell u_cell (
          .clk     (clk),
          .rst     (rst),
          .ctrl    (row_ctrl[r]),
          .a_in    (a_link[r][c]),
          .a_in_v  (av_link[r][c]),
          .b_in    (b_link[r][c]),
          .sum_in  (sum_link[r][c+1]),
          .a_out   (a_link[r][c+1]),
          .a_out_v (av_link[r][c+1]),
          .b_out   (b_link[r+1][c]),
          .sum     (sum_link[r][c])
        );
      end
    end
  endgenerate

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      kcnt         <= '0;
      wcnt         <= '0;
      er           <= '0;
      ec           <= '0;
      result_valid <= 1'b0;
    end else begin
      // A result leaves unless a new one replaces it in the same cycle.
      if (result_valid && !result_stall && !emit_go) begin
        result_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (clr) begin
            state <= FEED;
            kcnt  <= '0;
          end
        end
        FEED: begin
          if (kcnt == nk - 9'd1) begin
            state <= WAIT;
            wcnt  <= '0;
          end else begin
            kcnt <= kcnt + 9'd1;
          end
        end
        WAIT: begin
          if (wcnt == WW'(DRAIN)) begin
            state <= EMIT;
            er    <= '0;
            ec    <= '0;
          end else begin
            wcnt <= wcnt + WW'(1);
          end
        end
        EMIT: begin
          if (emit_go) begin
            result_valid       <= 1'b1;
            result.out_row     <= 3'(er);
            result.out_col     <= 3'(ec);
            result.product_sum <= row_head[er];
            result.last        <= emit_last;
            if (emit_last) begin
              state <= IDLE;
              kcnt  <= '0;
            end else if ({{(5-CW){1'b0}}, ec} == 5'(nc - 5'd1)) begin
              ec <= '0;
              er <= er + RW'(1);
            end else begin
              ec <= ec + CW'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

[sv/mmm_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mmm_checker: port-level checks of the mesh matrix multiplier
// Watches the configuration, item and result ports over time.
// ---------------------------------------------------------------------------
module mmm_checker
  import mmm_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    pready,
  input logic    item_valid,
  input logic    item_stall,
  input item_t   item,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // A stalled result transfer keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // The configuration port never waits.
  a_ready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

  // A load with no result pending produces no result.
  a_load: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !result_valid &&
    (item.operation == OP_LOAD_A || item.operation == OP_LOAD_B) |=> !result_valid)
    else $error("load produced a result");

  // A run transfer blocks further items while the mesh works.
  a_run: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && item.operation == OP_RUN |=> item_stall)
    else $error("item accepted during run");

endmodule

bind mesh_matrix_multiply mmm_checker u_mmm_checker (
  .clk          (clk),
  .rst          (rst),
  .pready       (pready),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
